// ===== design/bounding_box_frame_overlay_macros.svh =====
// Assertion macros used by the bounding box overlay output stage.
`ifndef BOUNDING_BOX_FRAME_OVERLAY_MACROS_SVH
`define BOUNDING_BOX_FRAME_OVERLAY_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BBFO_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bbfo assertion failed");

// Next-cycle implication, disabled during reset.
`define BBFO_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bbfo assertion failed");

`endif

// ===== design/bbfo_pkg.sv =====
// Types, constants and helpers for the bounding box overlay.
package bbfo_pkg;

  localparam int MAX_ROWS    = 64;
  localparam int MAX_COLUMNS = 64;
  localparam int DEPTH       = MAX_ROWS * MAX_COLUMNS;
  localparam int ROW_W       = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COL_W       = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int ADDR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W       = 7;
  localparam int CFG_IDX_W   = 2;
  localparam int PIX_W       = 8;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = CFG_IDX_W'(1);

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_FETCH = 1'b1;

  localparam logic [PIX_W-1:0] MARK_CHAR = PIX_W'(49);
  localparam logic [PIX_W-1:0] RING_CHAR = PIX_W'(42);
  localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(64);
  localparam logic [CNT_W-1:0] ROW_LIMIT = CNT_W'(MAX_ROWS);
  localparam logic [CNT_W-1:0] COL_LIMIT = CNT_W'(MAX_COLUMNS);

  typedef struct packed {
    logic             cmd;
    logic [PIX_W-1:0] pixel_in;
  } in_word_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic             row_end;
    logic             frame_end;
  } out_word_t;

  typedef struct packed {
    logic ring;
    logic row_end;
    logic frame_end;
  } fetch_meta_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [PIX_W-1:0]  wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  function automatic logic [CNT_W-1:0] clamp_size(input logic [CNT_W-1:0] v,
                                                  input logic [CNT_W-1:0] limit);
    logic [CNT_W-1:0] res;
    res = v;
    if (v == '0) begin
      res = CNT_W'(1);
    end else if (v > limit) begin
      res = limit;
    end
    return res;
  endfunction

endpackage

// ===== design/bbfo_store.sv =====
// Character store with one write port and one registered read port.
module bbfo_store (
  input  logic                       clk,
  input  bbfo_pkg::mem_req_t         req,
  output logic [bbfo_pkg::PIX_W-1:0] rdata
);
  import bbfo_pkg::*;

  logic [PIX_W-1:0] mem [DEPTH];
  logic [PIX_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata_r <= mem[req.raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== design/bbfo_frame_ctrl.sv =====
// Size registers, load and fetch counters, bounding box tracking and ring test.
module bbfo_frame_ctrl (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_accept,
  input  logic [bbfo_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bbfo_pkg::CNT_W-1:0]     cfg_data,
  input  logic                           in_accept,
  input  bbfo_pkg::in_word_t             in_word,
  output bbfo_pkg::mem_req_t             mem_req,
  output logic                           fetch_valid,
  output bbfo_pkg::fetch_meta_t          fetch_meta
);
  import bbfo_pkg::*;

  logic [CNT_W-1:0] row_count_r, row_count_nxt;
  logic [CNT_W-1:0] col_count_r, col_count_nxt;
  logic [CNT_W-1:0] load_row_r, load_row_nxt;
  logic [COL_W-1:0] load_col_r, load_col_nxt;
  logic [ROW_W-1:0] emit_row_r, emit_row_nxt;
  logic [COL_W-1:0] emit_col_r, emit_col_nxt;
  logic [ROW_W-1:0] top_r, top_nxt, bottom_r, bottom_nxt;
  logic [COL_W-1:0] left_r, left_nxt, right_r, right_nxt;
  logic             marked_r, marked_nxt;

  logic [CNT_W-1:0] rows, cols;
  logic [CNT_W-1:0] load_col_inc, emit_row_inc, emit_col_inc;
  logic             cfg_hit, do_load, do_fetch, is_mark;
  logic             last_col, last_row;
  logic [ROW_W:0]   r_ext, top_ext, bot_ext;
  logic [COL_W:0]   c_ext, left_ext, right_ext;
  logic             in_outer, in_inner;

  assign rows = clamp_size(row_count_r, ROW_LIMIT);
  assign cols = clamp_size(col_count_r, COL_LIMIT);

  assign cfg_hit  = cfg_accept && (cfg_index == REG_ROW_COUNT ||
                                   cfg_index == REG_COLUMN_COUNT);
  assign do_load  = in_accept && (in_word.cmd == CMD_LOAD) && (load_row_r < rows);
  assign do_fetch = in_accept && (in_word.cmd == CMD_FETCH);
  assign is_mark  = (in_word.pixel_in == MARK_CHAR);

  assign load_col_inc = CNT_W'(load_col_r) + CNT_W'(1);
  assign emit_col_inc = CNT_W'(emit_col_r) + CNT_W'(1);
  assign emit_row_inc = CNT_W'(emit_row_r) + CNT_W'(1);
  assign last_col     = (emit_col_inc >= cols);
  assign last_row     = (emit_row_inc >= rows);

  // ring test in widened unsigned math: top-1 <= r  <=>  r+1 >= top
  assign r_ext     = {1'b0, emit_row_r};
  assign c_ext     = {1'b0, emit_col_r};
  assign top_ext   = {1'b0, top_r};
  assign bot_ext   = {1'b0, bottom_r};
  assign left_ext  = {1'b0, left_r};
  assign right_ext = {1'b0, right_r};
  assign in_outer  = (r_ext + (ROW_W+1)'(1) >= top_ext) &&
                     (r_ext <= bot_ext + (ROW_W+1)'(1)) &&
                     (c_ext + (COL_W+1)'(1) >= left_ext) &&
                     (c_ext <= right_ext + (COL_W+1)'(1));
  assign in_inner  = (emit_row_r >= top_r) && (emit_row_r <= bottom_r) &&
                     (emit_col_r >= left_r) && (emit_col_r <= right_r);

  always_comb begin
    mem_req.we    = do_load;
    mem_req.waddr = ADDR_W'(load_row_r[ROW_W-1:0] * MAX_COLUMNS) + ADDR_W'(load_col_r);
    mem_req.wdata = in_word.pixel_in;
    mem_req.re    = do_fetch;
    mem_req.raddr = ADDR_W'(emit_row_r * MAX_COLUMNS) + ADDR_W'(emit_col_r);
  end

  assign fetch_valid          = do_fetch;
  assign fetch_meta.ring      = marked_r && in_outer && !in_inner;
  assign fetch_meta.row_end   = last_col;
  assign fetch_meta.frame_end = last_col && last_row;

  always_comb begin
    row_count_nxt = row_count_r;
    col_count_nxt = col_count_r;
    load_row_nxt  = load_row_r;
    load_col_nxt  = load_col_r;
    emit_row_nxt  = emit_row_r;
    emit_col_nxt  = emit_col_r;
    top_nxt       = top_r;
    bottom_nxt    = bottom_r;
    left_nxt      = left_r;
    right_nxt     = right_r;
    marked_nxt    = marked_r;
    if (cfg_hit || (do_fetch && last_col && last_row)) begin
      if (cfg_accept && cfg_index == REG_ROW_COUNT) begin
        row_count_nxt = cfg_data;
      end
      if (cfg_accept && cfg_index == REG_COLUMN_COUNT) begin
        col_count_nxt = cfg_data;
      end
      load_row_nxt = '0;
      load_col_nxt = '0;
      emit_row_nxt = '0;
      emit_col_nxt = '0;
      top_nxt      = '1;
      left_nxt     = '1;
      bottom_nxt   = '0;
      right_nxt    = '0;
      marked_nxt   = 1'b0;
    end else if (do_load) begin
      if (is_mark) begin
        marked_nxt = 1'b1;
        if (!marked_r) begin
          top_nxt    = load_row_r[ROW_W-1:0];
          bottom_nxt = load_row_r[ROW_W-1:0];
          left_nxt   = load_col_r;
          right_nxt  = load_col_r;
        end else begin
          if (load_row_r[ROW_W-1:0] < top_r) begin
            top_nxt = load_row_r[ROW_W-1:0];
          end
          if (load_row_r[ROW_W-1:0] > bottom_r) begin
            bottom_nxt = load_row_r[ROW_W-1:0];
          end
          if (load_col_r < left_r) begin
            left_nxt = load_col_r;
          end
          if (load_col_r > right_r) begin
            right_nxt = load_col_r;
          end
        end
      end
      if (load_col_inc >= cols) begin
        load_col_nxt = '0;
        load_row_nxt = load_row_r + CNT_W'(1);
      end else begin
        load_col_nxt = load_col_inc[COL_W-1:0];
      end
    end else if (do_fetch) begin
      if (last_col) begin
        emit_col_nxt = '0;
        emit_row_nxt = emit_row_inc[ROW_W-1:0];
      end else begin
        emit_col_nxt = emit_col_inc[COL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r <= CNT_RESET;
      col_count_r <= CNT_RESET;
      load_row_r  <= '0;
      load_col_r  <= '0;
      emit_row_r  <= '0;
      emit_col_r  <= '0;
      top_r       <= '1;
      left_r      <= '1;
      bottom_r    <= '0;
      right_r     <= '0;
      marked_r    <= 1'b0;
    end else begin
      row_count_r <= row_count_nxt;
      col_count_r <= col_count_nxt;
      load_row_r  <= load_row_nxt;
      load_col_r  <= load_col_nxt;
      emit_row_r  <= emit_row_nxt;
      emit_col_r  <= emit_col_nxt;
      top_r       <= top_nxt;
      left_r      <= left_nxt;
      bottom_r    <= bottom_nxt;
      right_r     <= right_nxt;
      marked_r    <= marked_nxt;
    end
  end

endmodule

// ===== design/bbfo_out_stage.sv =====
// Read stage and output register: applies the ring overlay and handles backpressure.
module bbfo_out_stage (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       fetch_valid,
  input  bbfo_pkg::fetch_meta_t      fetch_meta,
  input  logic [bbfo_pkg::PIX_W-1:0] rdata,
  output logic                       in_ready,
  output logic                       out_valid,
  input  logic                       out_ready,
  output bbfo_pkg::out_word_t        out_word
);
  import bbfo_pkg::*;
`include "bounding_box_frame_overlay_macros.svh"

  logic        rd_valid_r, rd_valid_nxt;
  fetch_meta_t meta_r;
  logic        out_valid_r, out_valid_nxt;
  out_word_t   out_word_r;
  logic        adv;

  assign adv      = rd_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !rd_valid_r || !out_valid_r || out_ready;

  always_comb begin
    rd_valid_nxt = rd_valid_r;
    if (fetch_valid) begin
      rd_valid_nxt = 1'b1;
    end else if (adv) begin
      rd_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_valid_r  <= rd_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fetch_valid) begin
      meta_r <= fetch_meta;
    end
    if (adv) begin
      out_word_r.pixel_out <= meta_r.ring ? RING_CHAR : rdata;
      out_word_r.row_end   <= meta_r.row_end;
      out_word_r.frame_end <= meta_r.frame_end;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  `BBFO_ASSERT_NOW(a_frame_end_ends_row, clk, rst_n, out_valid_r && out_word_r.frame_end, out_word_r.row_end)
  `BBFO_ASSERT_NOW(a_stall_only_when_full, clk, rst_n, !in_ready, rd_valid_r && out_valid_r && !out_ready)
  `BBFO_ASSERT_NEXT(a_read_held_on_stall, clk, rst_n, rd_valid_r && out_valid_r && !out_ready, rd_valid_r && $stable(meta_r))
  `BBFO_ASSERT_NOW(a_no_fetch_when_blocked, clk, rst_n, fetch_valid, in_ready)

endmodule

// ===== design/bounding_box_frame_overlay.sv =====
// Throughput is set by the single store port pair: one word per cycle, loads and fetches alike,
// while in_ready is high. A fetch result passes the store read and output registers.
// Loads and configuration writes produce no result; cfg_ready is always high.
// Reset: sizes return to 64x64, counters and the box clear; store contents stay undefined.
// Top level of the bounding box ring overlay.
module bounding_box_frame_overlay (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  bbfo_pkg::in_word_t             in_word,
  output logic                           out_valid,
  input  logic                           out_ready,
  output bbfo_pkg::out_word_t            out_word,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bbfo_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bbfo_pkg::CNT_W-1:0]     cfg_data
);
  import bbfo_pkg::*;

  mem_req_t         mem_req;
  logic [PIX_W-1:0] rdata;
  logic             fetch_valid;
  fetch_meta_t      fetch_meta;
  logic             in_accept;

  assign cfg_ready = 1'b1;
  assign in_accept = in_valid && in_ready;

  bbfo_frame_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_accept  (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_accept   (in_accept),
    .in_word     (in_word),
    .mem_req     (mem_req),
    .fetch_valid (fetch_valid),
    .fetch_meta  (fetch_meta)
  );

  bbfo_store u_store (
    .clk   (clk),
    .req   (mem_req),
    .rdata (rdata)
  );

  bbfo_out_stage u_out (
    .clk         (clk),
    .rst_n       (rst_n),
    .fetch_valid (fetch_valid),
    .fetch_meta  (fetch_meta),
    .rdata       (rdata),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_word    (out_word)
  );

endmodule

// ===== tb/sv/tb_bounding_box_frame_overlay.sv =====
// Self-checking testbench for bounding_box_frame_overlay: grid load, ring overlay and fetch.
module tb_bounding_box_frame_overlay;
  import bbfo_pkg::*;

  localparam int PLAN = 0;
  localparam int CHECK = 1;
  localparam int HOLD_LEN = 300;
  localparam int STALL_LIMIT = 3000;
  localparam int DRAIN_GAP = 4;
  localparam int ITEM_GOAL = 1400;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(3);

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_word_t in_word = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_word_t out_word;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CNT_W-1:0] cfg_data = '0;

  bounding_box_frame_overlay DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_word(in_word),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_word(out_word),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Two copies of the overlay state: one steers stimulus, one checks the DUT.
  logic [PIX_W-1:0] img [2][DEPTH];
  bit written [DEPTH];
  logic [CNT_W-1:0] rows_reg [2];
  logic [CNT_W-1:0] cols_reg [2];
  int ld_r [2];
  int ld_c [2];
  int em_r [2];
  int em_c [2];
  int mark_top [2];
  int mark_bot [2];
  int mark_lft [2];
  int mark_rgt [2];
  bit has_mark [2];

  in_word_t pending_words [$];
  out_word_t due_words [$];
  int words_planned = 0;
  int words_taken = 0;
  int items_planned = 0;
  int fail_count = 0;
  int quiet_cycles = 0;
  int send_gap_pct = 0;
  int recv_stall_pct = 0;
  int hold_asks = 0;
  int hold_served = 0;
  int hold_left = 0;
  logic in_fire = 1'b0;
  logic cfg_fire = 1'b0;

  function automatic int eff_size(logic [CNT_W-1:0] v);
    if (v == '0) return 1;
    if (v > CNT_W'(64)) return 64;
    return int'(v);
  endfunction

  function automatic void restart(int k);
    ld_r[k] = 0;
    ld_c[k] = 0;
    em_r[k] = 0;
    em_c[k] = 0;
    has_mark[k] = 1'b0;
  endfunction

  function automatic void reset_model(int k);
    rows_reg[k] = CNT_W'(64);
    cols_reg[k] = CNT_W'(64);
    restart(k);
  endfunction

  function automatic void apply_reg(int k, logic [CFG_IDX_W-1:0] idx, logic [CNT_W-1:0] val);
    if (idx == REG_ROW_COUNT) begin
      rows_reg[k] = val;
    end else if (idx == REG_COLUMN_COUNT) begin
      cols_reg[k] = val;
    end else begin
      return;
    end
    restart(k);
  endfunction

  function automatic bit advance_overlay(int k, in_word_t w, output out_word_t o);
    int nr;
    int nc;
    int r;
    int c;
    int a;
    bit ring;
    nr = eff_size(rows_reg[k]);
    nc = eff_size(cols_reg[k]);
    o = '0;
    if (w.cmd == CMD_LOAD) begin
      if (ld_r[k] >= nr) return 1'b0;
      r = ld_r[k];
      c = ld_c[k];
      a = r * MAX_COLUMNS + c;
      img[k][a] = w.pixel_in;
      written[a] = 1'b1;
      if (w.pixel_in == MARK_CHAR) begin
        if (!has_mark[k]) begin
          mark_top[k] = r;
          mark_bot[k] = r;
          mark_lft[k] = c;
          mark_rgt[k] = c;
          has_mark[k] = 1'b1;
        end else begin
          if (r < mark_top[k]) mark_top[k] = r;
          if (r > mark_bot[k]) mark_bot[k] = r;
          if (c < mark_lft[k]) mark_lft[k] = c;
          if (c > mark_rgt[k]) mark_rgt[k] = c;
        end
      end
      ld_c[k]++;
      if (ld_c[k] >= nc) begin
        ld_c[k] = 0;
        ld_r[k]++;
      end
      return 1'b0;
    end
    r = em_r[k];
    c = em_c[k];
    ring = has_mark[k] &&
           r >= mark_top[k] - 1 && r <= mark_bot[k] + 1 &&
           c >= mark_lft[k] - 1 && c <= mark_rgt[k] + 1 &&
           !(r >= mark_top[k] && r <= mark_bot[k] && c >= mark_lft[k] && c <= mark_rgt[k]);
    o.pixel_out = ring ? RING_CHAR : img[k][r * MAX_COLUMNS + c];
    o.row_end = (c + 1 >= nc);
    o.frame_end = o.row_end && (r + 1 >= nr);
    if (o.frame_end) begin
      restart(k);
    end else if (o.row_end) begin
      em_c[k] = 0;
      em_r[k] = r + 1;
    end else begin
      em_c[k] = c + 1;
    end
    return 1'b1;
  endfunction

  function automatic out_word_t plan_word(logic cmd, logic [PIX_W-1:0] px);
    in_word_t w;
    out_word_t o;
    w.cmd = cmd;
    w.pixel_in = px;
    if (cmd == CMD_FETCH || ld_r[PLAN] < eff_size(rows_reg[PLAN])) items_planned++;
    void'(advance_overlay(PLAN, w, o));
    pending_words.push_back(w);
    words_planned++;
    return o;
  endfunction

  // A fetch is safe when its cell holds data and it does not close the frame.
  function automatic bit early_fetch_ok();
    bit last;
    last = (em_r[PLAN] + 1 >= eff_size(rows_reg[PLAN])) &&
           (em_c[PLAN] + 1 >= eff_size(cols_reg[PLAN]));
    return written[em_r[PLAN] * MAX_COLUMNS + em_c[PLAN]] && !last;
  endfunction

  function automatic logic [PIX_W-1:0] load_char(int mark_pct);
    logic [PIX_W-1:0] px;
    if ($urandom_range(0, 99) < mark_pct) return MARK_CHAR;
    px = PIX_W'($urandom_range(0, 255));
    if (px == MARK_CHAR) px = RING_CHAR;
    return px;
  endfunction

  task automatic plan_frame(int mark_pct, int noise_pct, int cut);
    int loads;
    out_word_t o;
    loads = 0;
    while (ld_r[PLAN] < eff_size(rows_reg[PLAN])) begin
      if (cut >= 0 && loads == cut) return;
      if ($urandom_range(0, 99) < noise_pct && early_fetch_ok())
        void'(plan_word(CMD_FETCH, PIX_W'($urandom_range(0, 255))));
      void'(plan_word(CMD_LOAD, load_char(mark_pct)));
      loads++;
    end
    if ($urandom_range(0, 2) == 0)
      repeat ($urandom_range(1, 3)) void'(plan_word(CMD_LOAD, load_char(50)));
    do begin
      o = plan_word(CMD_FETCH, PIX_W'($urandom_range(0, 255)));
    end while (!o.frame_end);
  endtask

  task automatic drain();
    while (words_taken != words_planned || due_words.size() != 0) @(negedge clk);
    repeat (DRAIN_GAP) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CNT_W-1:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(negedge clk); while (!cfg_fire);
    cfg_valid <= 1'b0;
    apply_reg(PLAN, idx, val);
    @(negedge clk);
  endtask

  // Input driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (pending_words.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
        in_word <= pending_words.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result backpressure, with long holds on request
  always @(negedge clk) begin
    if (hold_asks != hold_served) begin
      hold_served = hold_asks;
      hold_left = HOLD_LEN;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Monitor, scoreboard and watchdog
  always @(posedge clk) begin
    out_word_t want;
    out_word_t got;
    if (!rst_n) begin
      in_fire <= 1'b0;
      cfg_fire <= 1'b0;
      quiet_cycles = 0;
    end else begin
      in_fire <= in_valid && in_ready;
      cfg_fire <= cfg_valid && cfg_ready;
      if (cfg_valid && cfg_ready) apply_reg(CHECK, cfg_index, cfg_data);
      if (in_valid && in_ready) begin
        words_taken++;
        if (advance_overlay(CHECK, in_word, want)) due_words.push_back(want);
      end
      if (out_valid && out_ready) begin
        got = out_word;
        if (due_words.size() == 0) begin
          $error("unexpected word: pixel_out %0h row_end %0b frame_end %0b",
                 got.pixel_out, got.row_end, got.frame_end);
          fail_count++;
        end else begin
          want = due_words.pop_front();
          if (got.pixel_out !== want.pixel_out) begin
            $error("pixel_out: expected %0h, got %0h", want.pixel_out, got.pixel_out);
            fail_count++;
          end
          if (got.row_end !== want.row_end) begin
            $error("row_end: expected %0b, got %0b", want.row_end, got.row_end);
            fail_count++;
          end
          if (got.frame_end !== want.frame_end) begin
            $error("frame_end: expected %0b, got %0b", want.frame_end, got.frame_end);
            fail_count++;
          end
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
          $display("bounding_box_frame_overlay test failed");
          $finish;
        end
      end
    end
  end

  initial begin
    logic [PIX_W-1:0] seed_px [12];
    logic [CNT_W-1:0] rows_v;
    logic [CNT_W-1:0] cols_v;
    int phase;
    int cells;
    int frames;
    int mark_pct;
    int noise_pct;
    int tail;

    reset_model(PLAN);
    reset_model(CHECK);
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: mark in the top-left corner, extreme bytes, one load past the grid
    seed_px = '{MARK_CHAR, 8'h00, 8'hFF, 8'h7F,
                8'h80, 8'h01, 8'h30, 8'h32,
                RING_CHAR, 8'h55, 8'hAA, 8'hFE};
    write_reg(REG_ROW_COUNT, CNT_W'(3));
    write_reg(REG_COLUMN_COUNT, CNT_W'(4));
    foreach (seed_px[i]) void'(plan_word(CMD_LOAD, seed_px[i]));
    void'(plan_word(CMD_LOAD, MARK_CHAR));
    repeat (12) void'(plan_word(CMD_FETCH, 8'h00));
    drain();

    phase = 0;
    while (items_planned < ITEM_GOAL) begin
      case (phase)
        0: begin rows_v = CNT_W'(0);   cols_v = CNT_W'(127); end
        1: begin rows_v = CNT_W'(64);  cols_v = CNT_W'(2);   end
        2: begin rows_v = CNT_W'(127); cols_v = CNT_W'(1);   end
        3: begin rows_v = CNT_W'(2);   cols_v = CNT_W'(64);  end
        4: begin rows_v = CNT_W'(8);   cols_v = CNT_W'(8);   end
        5: begin rows_v = CNT_W'(1);   cols_v = CNT_W'(1);   end
        default: begin
          case ($urandom_range(0, 7))
            0: begin
              rows_v = CNT_W'($urandom_range(0, 127));
              cols_v = CNT_W'($urandom_range(0, 2));
            end
            1: begin
              rows_v = CNT_W'($urandom_range(0, 2));
              cols_v = CNT_W'($urandom_range(0, 127));
            end
            default: begin
              rows_v = CNT_W'($urandom_range(1, 8));
              cols_v = CNT_W'($urandom_range(1, 8));
            end
          endcase
        end
      endcase

      case (phase % 4)
        0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_gap_pct = 78; recv_stall_pct = 0;  end
        2: begin send_gap_pct = 0;  recv_stall_pct = 78; end
        default: begin send_gap_pct = 25; recv_stall_pct = 25; end
      endcase

      if ($urandom_range(0, 3) == 0)
        write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B,
                  CNT_W'($urandom_range(0, 127)));
      write_reg(REG_ROW_COUNT, rows_v);
      write_reg(REG_COLUMN_COUNT, cols_v);

      // Block fills up while results are held off
      if (phase == 4) hold_asks++;

      cells = eff_size(rows_v) * eff_size(cols_v);
      frames = (cells > 32) ? 1 : $urandom_range(2, 5);
      for (int f = 0; f < frames; f++) begin
        case ($urandom_range(0, 3))
          0: mark_pct = 0;
          1: mark_pct = 4;
          2: mark_pct = 15;
          default: mark_pct = 40;
        endcase
        noise_pct = $urandom_range(0, 1) ? 0 : 15;
        plan_frame(mark_pct, noise_pct, -1);
        if (phase == 5 && f == 0) drain();
      end

      // Broken frames: cut short, then resumed after a write to an unused index or
      // left for the next size write to abandon
      tail = $urandom_range(0, 3);
      if (tail < 2) begin
        plan_frame(15, 10, $urandom_range(0, cells - 1));
        if (tail == 0) begin
          drain();
          write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B,
                    CNT_W'($urandom_range(0, 127)));
          plan_frame(15, 10, -1);
        end
      end
      drain();
      phase++;
    end

    drain();
    if (fail_count == 0) begin
      $display("bounding_box_frame_overlay test passed");
    end else begin
      $display("bounding_box_frame_overlay test failed");
    end
    $finish;
  end

endmodule
